// ----- sv/rwcsp_pkg.sv -----
`default_nettype none

package rwcsp_pkg;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_FLUSH  = 2'd1,
    OP_PAUSE  = 2'd2,
    OP_RESUME = 2'd3
  } op_t;

  localparam logic        KIND_WRITE  = 1'b0;
  localparam logic        KIND_DELAY  = 1'b1;
  localparam logic [4:0]  VOLUME_REG  = 5'h18;
  localparam logic [23:0] MIN_DELAY   = 24'd20;
  localparam logic [23:0] FLOOR_DELAY = 24'd10;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic        kind;
    logic [4:0]  chip_reg;
    logic [7:0]  chip_data;
    logic [23:0] ticks;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- sv/register_write_command_stream_parser.sv -----
`default_nettype none

// channel   direction  handshake              payload
// in_       input      in_valid / in_ready    in_operation[1:0], in_stream_byte[7:0]
// out_      output     out_valid / out_ready  out_kind, out_chip_reg[4:0],
//                                             out_chip_data[7:0], out_delay_ticks[23:0]
// cfg_      input      cfg_we                 cfg_wdata[15:0] (timer adjust)
//
// one input beat per cycle while the queue is not full; the parser classifies it in the cycle it is taken
// a result beat is written into the queue and then into the output register
// before out_valid rises
// a queue of QUEUE_DEPTH entries sits between parser and output register;
// in_ready drops only while that queue is full
// rst_n is synchronous: parser state, queue, output valid and timer adjust clear

module register_write_command_stream_parser #(
  parameter int QUEUE_DEPTH = rwcsp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_stream_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [4:0]       out_chip_reg,
  output logic [7:0]       out_chip_data,
  output logic [23:0]      out_delay_ticks,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import rwcsp_pkg::*;

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;
  logic    push;
  logic    pop;

  rwcsp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_stream_byte (in_stream_byte),
    .q_stat         (q_stat),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  rwcsp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  rwcsp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .q_stat          (q_stat),
    .pop_cmd         (pop_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_chip_reg    (out_chip_reg),
    .out_chip_data   (out_chip_data),
    .out_delay_ticks (out_delay_ticks)
  );

endmodule

`default_nettype wire

// ----- sv/rwcsp_front.sv -----
`default_nettype none

module rwcsp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_operation,
  input  wire logic [7:0]        in_stream_byte,
  input  rwcsp_pkg::q_stat_t     q_stat,
  output logic                   push,
  output rwcsp_pkg::cmd_t        push_cmd
);
  import rwcsp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DATA,
    PH_DHI,
    PH_DMID,
    PH_DLO
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  pend_reg_r, pend_reg_nxt;
  logic [7:0]  dly_hi_r, dly_hi_nxt;
  logic [7:0]  dly_mid_r, dly_mid_nxt;
  logic [7:0]  vol_r, vol_nxt;
  logic        accept;
  op_t         op;
  logic [23:0] raw_delay;

  assign in_ready  = !q_stat.full;
  assign accept    = in_valid && in_ready;
  assign op        = op_t'(in_operation);
  assign raw_delay = {dly_hi_r, dly_mid_r, in_stream_byte};

  always_comb begin
    phase_nxt    = phase_r;
    pend_reg_nxt = pend_reg_r;
    dly_hi_nxt   = dly_hi_r;
    dly_mid_nxt  = dly_mid_r;
    vol_nxt      = vol_r;
    push         = 1'b0;
    push_cmd     = '0;
    if (accept) begin
      case (op)
        OP_FLUSH: begin
          phase_nxt    = PH_IDLE;
          pend_reg_nxt = '0;
          dly_hi_nxt   = '0;
          dly_mid_nxt  = '0;
        end
        OP_PAUSE: begin
          push               = 1'b1;
          push_cmd.kind      = KIND_WRITE;
          push_cmd.chip_reg  = VOLUME_REG;
        end
        OP_RESUME: begin
          push               = 1'b1;
          push_cmd.kind      = KIND_WRITE;
          push_cmd.chip_reg  = VOLUME_REG;
          push_cmd.chip_data = vol_r;
        end
        default: begin
          case (phase_r)
            PH_DATA: begin
              phase_nxt          = PH_IDLE;
              push               = 1'b1;
              push_cmd.kind      = KIND_WRITE;
              push_cmd.chip_reg  = pend_reg_r;
              push_cmd.chip_data = in_stream_byte;
              if (pend_reg_r == VOLUME_REG) begin
                vol_nxt = in_stream_byte;
              end
            end
            PH_DHI: begin
              dly_hi_nxt  = in_stream_byte;
              dly_mid_nxt = '0;
              phase_nxt   = PH_DMID;
            end
            PH_DMID: begin
              dly_mid_nxt = in_stream_byte;
              phase_nxt   = PH_DLO;
            end
            PH_DLO: begin
              phase_nxt = PH_IDLE;
              if (raw_delay >= MIN_DELAY) begin
                push           = 1'b1;
                push_cmd.kind  = KIND_DELAY;
                push_cmd.ticks = raw_delay;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
              if (in_stream_byte inside {[8'h00:8'h1f]}) begin
                pend_reg_nxt = in_stream_byte[4:0];
                phase_nxt    = PH_DATA;
              end else if (in_stream_byte inside {[8'h20:8'h3f]}) begin
                dly_hi_nxt  = '0;
                dly_mid_nxt = '0;
                phase_nxt   = PH_DHI;
              end
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      pend_reg_r <= '0;
      dly_hi_r   <= '0;
      dly_mid_r  <= '0;
      vol_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pend_reg_r <= pend_reg_nxt;
      dly_hi_r   <= dly_hi_nxt;
      dly_mid_r  <= dly_mid_nxt;
      vol_r      <= vol_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rwcsp_fifo.sv -----
`default_nettype none

module rwcsp_fifo #(
  parameter int DEPTH = rwcsp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  rwcsp_pkg::cmd_t    push_cmd,
  input  wire logic          pop,
  output rwcsp_pkg::cmd_t    pop_cmd,
  output rwcsp_pkg::q_stat_t q_stat
);
  import rwcsp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_cmd      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rwcsp_back.sv -----
`default_nettype none

module rwcsp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata,
  input  rwcsp_pkg::q_stat_t q_stat,
  input  rwcsp_pkg::cmd_t    pop_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_kind,
  output logic [4:0]         out_chip_reg,
  output logic [7:0]         out_chip_data,
  output logic [23:0]        out_delay_ticks
);
  import rwcsp_pkg::*;

  logic [15:0] timer_adj_r;
  logic        out_valid_r;
  logic        kind_r;
  logic [4:0]  chip_reg_r;
  logic [7:0]  chip_data_r;
  logic [23:0] ticks_r;
  logic [23:0] adj_ext;
  logic [23:0] diff;
  logic [23:0] ticks_nxt;

  assign pop     = !q_stat.empty && (!out_valid_r || out_ready);
  assign adj_ext = {8'd0, timer_adj_r};
  assign diff    = pop_cmd.ticks - adj_ext;

  always_comb begin
    ticks_nxt = pop_cmd.ticks;
    if (pop_cmd.kind == KIND_DELAY) begin
      if ((adj_ext < pop_cmd.ticks) && (diff > FLOOR_DELAY)) begin
        ticks_nxt = diff;
      end else begin
        ticks_nxt = FLOOR_DELAY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_adj_r <= '0;
    end else if (cfg_we) begin
      timer_adj_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r      <= pop_cmd.kind;
      chip_reg_r  <= pop_cmd.chip_reg;
      chip_data_r <= pop_cmd.chip_data;
      ticks_r     <= ticks_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_chip_reg    = chip_reg_r;
  assign out_chip_data   = chip_data_r;
  assign out_delay_ticks = ticks_r;

endmodule

`default_nettype wire

// ----- sv/rwcsp_checker.sv -----
`default_nettype none

module rwcsp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_kind,
  input wire logic [4:0]  out_chip_reg,
  input wire logic [7:0]  out_chip_data,
  input wire logic [23:0] out_delay_ticks
);
  import rwcsp_pkg::*;

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_chip_reg) && $stable(out_chip_data) && $stable(out_delay_ticks))
    else $error("out beat changed while stalled");

  a_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_WRITE |-> out_delay_ticks == '0)
    else $error("write beat carries delay ticks");

  a_delay_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DELAY |->
      out_chip_reg == '0 && out_chip_data == '0 && out_delay_ticks >= FLOOR_DELAY)
    else $error("delay beat malformed or below floor");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

endmodule

bind register_write_command_stream_parser rwcsp_checker u_rwcsp_checker (.*);

`default_nettype wire

// ----- test/tb_register_write_command_stream_parser.sv -----
`timescale 1ns / 1ps

module tb_register_write_command_stream_parser;
  import rwcsp_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [2:0] CLASS_WRITE = 3'b000;
  localparam logic [2:0] CLASS_DELAY = 3'b001;

  typedef enum logic [2:0] {
    WAIT_CMD,
    WAIT_DATA,
    WAIT_HI,
    WAIT_MID,
    WAIT_LO
  } parse_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [7:0]  in_stream_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [4:0]  out_chip_reg;
  logic [7:0]  out_chip_data;
  logic [23:0] out_delay_ticks;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  // predictor state
  parse_t      phase;
  logic [4:0]  pend_reg;
  logic [23:0] delay_acc;
  logic [7:0]  vol_keep;
  logic [15:0] adjust;

  cmd_t        chip_cmd_q[$];
  cmd_t        want;
  int          err_count = 0;
  int          beats_sent;
  int          cycle_count = 0;
  int          stall_left;
  bit          steady;

  register_write_command_stream_parser u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_stream_byte (in_stream_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_chip_reg   (out_chip_reg),
    .out_chip_data  (out_chip_data),
    .out_delay_ticks(out_delay_ticks),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("mismatch %s: got %0h, expected %0h", what, got, exp_val);
    err_count++;
  endtask

  // expected chip commands for one accepted beat
  task automatic decode_beat(input op_t op, input logic [7:0] b);
    cmd_t        c;
    logic [23:0] raw;
    c = '0;
    case (op)
      OP_FLUSH: begin
        phase = WAIT_CMD;
        pend_reg = '0;
        delay_acc = '0;
      end
      OP_PAUSE: begin
        c.kind = KIND_WRITE;
        c.chip_reg = VOLUME_REG;
        chip_cmd_q.push_back(c);
      end
      OP_RESUME: begin
        c.kind = KIND_WRITE;
        c.chip_reg = VOLUME_REG;
        c.chip_data = vol_keep;
        chip_cmd_q.push_back(c);
      end
      default: begin
        case (phase)
          WAIT_DATA: begin
            phase = WAIT_CMD;
            if (pend_reg == VOLUME_REG) vol_keep = b;
            c.kind = KIND_WRITE;
            c.chip_reg = pend_reg;
            c.chip_data = b;
            chip_cmd_q.push_back(c);
          end
          WAIT_HI: begin
            delay_acc = {b, 16'h0000};
            phase = WAIT_MID;
          end
          WAIT_MID: begin
            delay_acc = {delay_acc[23:16], b, 8'h00};
            phase = WAIT_LO;
          end
          WAIT_LO: begin
            raw = {delay_acc[23:8], b};
            delay_acc = raw;
            phase = WAIT_CMD;
            if (raw >= MIN_DELAY) begin
              c.kind = KIND_DELAY;
              if ({8'h00, adjust} < raw && raw - {8'h00, adjust} > FLOOR_DELAY)
                c.ticks = raw - {8'h00, adjust};
              else
                c.ticks = FLOOR_DELAY;
              chip_cmd_q.push_back(c);
            end
          end
          default: begin
            phase = WAIT_CMD;
            if (b[7:5] == CLASS_WRITE) begin
              pend_reg = b[4:0];
              phase = WAIT_DATA;
            end else if (b[7:5] == CLASS_DELAY) begin
              delay_acc = '0;
              phase = WAIT_HI;
            end
          end
        endcase
      end
    endcase
  endtask

  task automatic send_beat(input op_t op, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_operation = op;
    in_stream_byte = b;
    do @(posedge clk); while (!in_ready);
    decode_beat(op, b);
    beats_sent++;
  endtask

  task automatic send_write(input logic [4:0] chip_reg, input logic [7:0] data);
    send_beat(OP_BYTE, {CLASS_WRITE, chip_reg});
    send_beat(OP_BYTE, data);
  endtask

  task automatic send_delay(input logic [7:0] cmd, input logic [23:0] raw);
    send_beat(OP_BYTE, cmd);
    send_beat(OP_BYTE, raw[23:16]);
    send_beat(OP_BYTE, raw[15:8]);
    send_beat(OP_BYTE, raw[7:0]);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (chip_cmd_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_adjust(input logic [15:0] value);
    hold_until_drained();
    // beats without a result may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    adjust = value;
  endtask

  function automatic logic [23:0] random_delay();
    case ($urandom_range(0, 3))
      0: return 24'($urandom_range(0, 40));
      1: return {8'h00, adjust} + 24'($urandom_range(0, 24));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_directed_cases();
    send_write(5'h00, 8'h00);
    send_write(5'h1f, 8'hff);
    send_write(VOLUME_REG, 8'ha5);
    send_beat(OP_PAUSE, 8'h00);
    send_beat(OP_RESUME, 8'hff);
    // too short, dropped
    send_delay(8'h20, 24'd19);
    send_delay(8'h3f, 24'd20);
    send_delay(8'h25, 24'hffffff);
    // ignored command bytes
    send_beat(OP_BYTE, 8'h40);
    send_beat(OP_BYTE, 8'hff);
    // flush in the middle of a write
    send_beat(OP_BYTE, 8'h05);
    send_beat(OP_FLUSH, 8'h9c);
    send_write(5'h01, 8'h5a);
    // pause inside a delay does not disturb it
    send_beat(OP_BYTE, 8'h20);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_PAUSE, 8'h11);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'h30);
    // resume inside a volume write
    send_beat(OP_BYTE, {CLASS_WRITE, VOLUME_REG});
    send_beat(OP_RESUME, 8'h00);
    send_beat(OP_BYTE, 8'h3c);
  endtask

  task automatic test_timer_adjust();
    logic [15:0] adj_set[3];
    adj_set = '{16'hffff, 16'd10, 16'd1000};
    foreach (adj_set[i]) begin
      write_adjust(adj_set[i]);
      send_delay(8'h20, {8'h00, adj_set[i]} + 24'd10);
      send_delay(8'h21, {8'h00, adj_set[i]} + 24'd11);
      send_delay(8'h3e, 24'd20);
      send_delay(8'h2a, 24'hffffff);
    end
  endtask

  task automatic test_random_stream(input int n_beats);
    int stop_at;
    int pick;
    int k;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        if ($urandom_range(0, 3) == 0) send_write(VOLUME_REG, 8'($urandom));
        else send_write(5'($urandom), 8'($urandom));
      end else if (pick < 60) begin
        send_delay({CLASS_DELAY, 5'($urandom)}, random_delay());
      end else if (pick < 70) begin
        send_beat(op_t'($urandom_range(2, 3)), 8'($urandom));
      end else if (pick < 75) begin
        send_beat(OP_FLUSH, 8'($urandom));
      end else if (pick < 87) begin
        send_beat(OP_BYTE, 8'($urandom));
      end else begin
        // command cut short by an event
        send_beat(OP_BYTE, 8'($urandom_range(0, 63)));
        k = $urandom_range(0, 2);
        repeat (k) send_beat(OP_BYTE, 8'($urandom));
        send_beat(op_t'($urandom_range(1, 3)), 8'($urandom));
      end
    end
  endtask

  task automatic test_sender_hold();
    repeat (6) send_write(5'($urandom), 8'($urandom));
    hold_until_drained();
    repeat (4) send_delay({CLASS_DELAY, 5'($urandom)}, random_delay());
    send_beat(OP_RESUME, 8'h00);
  endtask

  // result side: random stalls, always ready while steady
  initial begin
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (steady) begin
        out_ready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready = 1'b0;
      end else if ($urandom_range(0, 99) < 70) begin
        out_ready = 1'b1;
      end else begin
        stall_left = pick_gap();
        out_ready = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (chip_cmd_q.size() == 0) begin
        report_mismatch("unexpected beat",
                        32'({out_kind, out_chip_reg, out_chip_data}), 32'd0);
      end else begin
        want = chip_cmd_q.pop_front();
        if (out_kind !== want.kind)
          report_mismatch("kind", 32'(out_kind), 32'(want.kind));
        if (out_chip_reg !== want.chip_reg)
          report_mismatch("chip_reg", 32'(out_chip_reg), 32'(want.chip_reg));
        if (out_chip_data !== want.chip_data)
          report_mismatch("chip_data", 32'(out_chip_data), 32'(want.chip_data));
        if (out_delay_ticks !== want.ticks)
          report_mismatch("delay_ticks", 32'(out_delay_ticks), 32'(want.ticks));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_BYTE;
    in_stream_byte = 8'h00;
    cfg_we = 1'b0;
    cfg_wdata = 16'h0000;
    beats_sent = 0;
    steady = 1'b0;
    phase = WAIT_CMD;
    pend_reg = '0;
    delay_acc = '0;
    vol_keep = '0;
    adjust = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_timer_adjust();

    steady = 1'b1;
    write_adjust(16'h0000);
    test_random_stream(250);
    steady = 1'b0;
    write_adjust(16'($urandom_range(0, 300)));
    test_random_stream(250);
    test_sender_hold();
    write_adjust(16'hffff);
    test_random_stream(200);
    write_adjust(16'($urandom));
    test_random_stream(250);

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
